// ===== rtl/sba_pkg.sv =====
// Shared types and codes for the sector bitmap allocator.
// Used by the controller, datapath and top level; depends on nothing.
package sba_pkg;

    // Sector capacity; the 12-bit sector ports address exactly this many.
    localparam int NUM_SECTORS = 4096;

    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_MARK    = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_HEADER   = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_WRITE,
        OP_TRIM,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage

// ===== rtl/sba_ctrl.sv =====
// Controller state machine for the sector bitmap allocator.
// Depends on sba_pkg; drives the datapath through dp_cmd_t.
module sba_ctrl
    import sba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       phase_done,
    input  logic [1:0] cmd_code,
    input  logic       fail,
    output logic       busy,
    output logic       done,
    output dp_cmd_t    dp_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_WRITE,
        S_TRIM,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        dp_cmd.op = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                dp_cmd.op = OP_CLEAR;
                if (phase_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                dp_cmd.op = OP_LOAD;
                if (fail)
                    state_next = S_DONE;
                else if (cmd_code == CMD_RESERVE)
                    state_next = S_SCAN;
                else if (cmd_code == CMD_QUERY)
                    state_next = S_DONE;
                else
                    state_next = S_WRITE;
            end
            S_SCAN:
            begin
                dp_cmd.op = OP_SCAN;
                if (phase_done)
                    state_next = fail ? S_DONE : S_WRITE;
            end
            S_WRITE:
            begin
                dp_cmd.op = OP_WRITE;
                if (phase_done)
                    state_next = (cmd_code == CMD_RELEASE) ? S_TRIM : S_DONE;
            end
            S_TRIM:
            begin
                dp_cmd.op = OP_TRIM;
                if (phase_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== rtl/sba_dp.sv =====
// Datapath of the sector bitmap allocator: bitmap, watermark and run logic.
// Depends on sba_pkg and sba_ram. One bit per RAM word, one per cycle except in trim.
module sba_dp
    import sba_pkg::*;
#(
    parameter int HEADER_SECTORS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     dp_cmd,
    input  logic        start_xfer,
    input  logic [1:0]  cmd,
    input  logic [11:0] sector_index,
    input  logic [12:0] sector_count,
    input  logic        mark_value,
    output logic        phase_done,
    output logic        fail,
    output logic [1:0]  cmd_code,
    output logic [11:0] result_sector,
    output logic        is_used,
    output logic [12:0] high_mark,
    output logic [1:0]  status
);

    localparam int AW = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] NS = CW'(NUM_SECTORS);
    localparam logic [CW-1:0] HS = CW'(HEADER_SECTORS);

    // Sector bits live in a one-bit-wide RAM; a clearing pass sets it up.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    sba_ram #(.WIDTH(1), .DEPTH(NUM_SECTORS)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [1:0]    cmd_reg;
    logic [CW-1:0] idx_reg, cnt_reg, hw_reg, ptr_reg, run_reg, rs_reg, end_reg;
    logic          val_reg, mval_reg, rd_valid_reg, used_reg;
    logic [1:0]    status_reg;
    logic [11:0]   res_reg;

    logic          found;
    logic [CW-1:0] run_next, rs_next;
    logic [CW:0]   idx_end, hw_end;
    logic          scan_end, no_space, write_last;
    logic          load_fail;
    logic [1:0]    load_status;

    // Scan bookkeeping; the pointer sits one sector ahead of the registered read.
    always_comb
    begin
        run_next = run_reg;
        rs_next  = rs_reg;
        found    = 1'b0;
        if (rd_valid_reg)
        begin
            if (ram_rdata)
            begin
                run_next = '0;
                rs_next  = ptr_reg;
            end
            else
            begin
                run_next = run_reg + CW'(1);
                found    = (run_next == cnt_reg);
            end
        end
    end

    assign idx_end    = {1'b0, idx_reg} + {1'b0, cnt_reg};
    assign hw_end     = {1'b0, hw_reg} + {1'b0, cnt_reg};
    assign scan_end   = !found && (ptr_reg >= hw_reg);
    assign no_space   = (dp_cmd.op == OP_SCAN) && scan_end && (hw_end > {1'b0, NS});
    assign write_last = (ptr_reg >= end_reg) || (ptr_reg + CW'(1) >= end_reg);

    // Checks that refuse a command before anything is touched.
    always_comb
    begin
        load_fail   = 1'b0;
        load_status = ST_OK;
        unique case (cmd_reg)
            CMD_RESERVE:
            begin
                load_fail = 1'b0;
            end
            CMD_RELEASE:
            begin
                if (idx_reg < HS)
                begin
                    load_fail   = 1'b1;
                    load_status = ST_HEADER;
                end
                else if (idx_end > {1'b0, NS})
                begin
                    load_fail   = 1'b1;
                    load_status = ST_RANGE;
                end
            end
            CMD_MARK:
            begin
                if (idx_end > {1'b0, NS})
                begin
                    load_fail   = 1'b1;
                    load_status = ST_RANGE;
                end
            end
            CMD_QUERY:
            begin
                if (idx_reg >= NS)
                    load_status = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[AW-1:0];
        ram_wdata = 1'b0;
        ram_raddr = ptr_reg[AW-1:0];
        phase_done = 1'b0;
        case (dp_cmd.op)
            OP_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (ptr_reg < HS);
                phase_done = (ptr_reg == NS - CW'(1));
            end
            OP_SCAN:
            begin
                phase_done = found || scan_end;
            end
            OP_WRITE:
            begin
                ram_we    = (ptr_reg < end_reg);
                ram_wdata = val_reg;
                phase_done = write_last;
            end
            OP_TRIM:
            begin
                ram_raddr = AW'(hw_reg - CW'(1));
                phase_done = (hw_reg <= HS) || (rd_valid_reg && ram_rdata);
            end
            default:
            begin
                ram_raddr = sector_index[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            hw_reg       <= HS;
            rd_valid_reg <= 1'b0;
            run_reg      <= '0;
            rs_reg       <= HS;
            end_reg      <= '0;
            val_reg      <= 1'b0;
            used_reg     <= 1'b0;
            res_reg      <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            case (dp_cmd.op)
                OP_CLEAR:
                begin
                    ptr_reg      <= ptr_reg + CW'(1);
                    rd_valid_reg <= 1'b0;
                end
                OP_LOAD:
                begin
                    ptr_reg      <= (cmd_reg == CMD_RELEASE || cmd_reg == CMD_MARK) ?
                                    idx_reg : HS;
                    run_reg      <= '0;
                    rs_reg       <= HS;
                    used_reg     <= (cmd_reg == CMD_QUERY && idx_reg < NS) ? ram_rdata : 1'b0;
                    res_reg      <= '0;
                    status_reg   <= load_status;
                    end_reg      <= idx_end[CW-1:0];
                    val_reg      <= (cmd_reg == CMD_MARK) ? mval_reg : (cmd_reg != CMD_RELEASE);
                    rd_valid_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    run_reg      <= run_next;
                    rs_reg       <= rs_next;
                    rd_valid_reg <= !found && (ptr_reg < hw_reg);
                    if (found)
                    begin
                        ptr_reg <= rs_next;
                        end_reg <= rs_next + cnt_reg;
                        res_reg <= rs_next[11:0];
                    end
                    else if (scan_end)
                    begin
                        if (no_space)
                            status_reg <= ST_NO_SPACE;
                        else
                        begin
                            ptr_reg <= hw_reg;
                            end_reg <= hw_end[CW-1:0];
                            res_reg <= hw_reg[11:0];
                        end
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                end
                OP_WRITE:
                begin
                    rd_valid_reg <= 1'b0;
                    if (ptr_reg < end_reg)
                        ptr_reg <= ptr_reg + CW'(1);
                    if (val_reg && cnt_reg != '0 && end_reg > hw_reg && write_last)
                        hw_reg <= end_reg;
                end
                OP_TRIM:
                begin
                    // Each tail sector is read, then checked before the watermark moves.
                    if (hw_reg > HS && rd_valid_reg && !ram_rdata)
                        hw_reg <= hw_reg - CW'(1);
                    rd_valid_reg <= (hw_reg > HS) && !rd_valid_reg;
                end
                default:
                begin
                    rd_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // Capture the command at the transfer; reserve count 0 counts as 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= CMD_RESERVE;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            mval_reg <= 1'b0;
        end
        else if (start_xfer)
        begin
            cmd_reg  <= cmd;
            idx_reg  <= CW'(sector_index);
            cnt_reg  <= (cmd == CMD_RESERVE && sector_count == 13'd0) ?
                        CW'(1) : CW'(sector_count);
            mval_reg <= mark_value;
        end
    end

    assign fail          = (dp_cmd.op == OP_LOAD && load_fail) || no_space;
    assign cmd_code      = cmd_reg;
    assign result_sector = (status_reg == ST_OK) ? res_reg : 12'd0;
    assign is_used       = used_reg;
    assign high_mark     = 13'(hw_reg);
    assign status        = status_reg;

endmodule

// ===== rtl/sba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used by the allocator datapath for the sector bitmap; no dependencies.
module sba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sector_bitmap_allocator_core.sv =====
// Channel  | Handshake       | Fields
// command  | start / busy    | cmd, sector_index, sector_count, mark_value
// result   | done (1 cycle)  | result_sector, is_used, high_mark, status
// Query and refused commands: after the transfer the core goes through load to done.
// Reserve scans the sectors up to the watermark for a free run, then writes the run it
// allots; mark writes the sectors of its range.
// Release writes its range, then trims free tail sectors off the watermark.
// After reset a clearing pass over every sector initializes the bitmap; busy is high.
// The receiver cannot stall; done marks the result for one cycle.
// Top level: joins sba_ctrl and sba_dp; depends on sba_pkg.
module sector_bitmap_allocator_core
    import sba_pkg::*;
#(
    parameter int HEADER_SECTORS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [11:0] sector_index,
    input  logic [12:0] sector_count,
    input  logic        mark_value,
    output logic        done,
    output logic [11:0] result_sector,
    output logic        is_used,
    output logic [12:0] high_mark,
    output logic [1:0]  status
);

    dp_cmd_t    dp_cmd;
    logic       phase_done, fail;
    logic [1:0] cmd_code;

    sba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .phase_done (phase_done),
        .cmd_code   (cmd_code),
        .fail       (fail),
        .busy       (busy),
        .done       (done),
        .dp_cmd     (dp_cmd)
    );

    sba_dp #(.HEADER_SECTORS(HEADER_SECTORS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .start_xfer    (start & ~busy),
        .cmd           (cmd),
        .sector_index  (sector_index),
        .sector_count  (sector_count),
        .mark_value    (mark_value),
        .phase_done    (phase_done),
        .fail          (fail),
        .cmd_code      (cmd_code),
        .result_sector (result_sector),
        .is_used       (is_used),
        .high_mark     (high_mark),
        .status        (status)
    );

endmodule
